>>> hdl/dbmp_pkg.sv
// Shared types and constants for the debounced button mode panel.
// No dependencies; used by every module under hdl.
package dbmp_pkg;

   localparam int NUM_BUTTONS       = 4;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NOW_BITS          = 32;
   localparam int DEBOUNCE_BITS     = 16;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd100;

   // button roles, by bit position in the level and press words
   localparam int BTN_TEMP  = 0;
   localparam int BTN_BADGE = 1;
   localparam int BTN_SEND  = 2;
   localparam int BTN_CLEAR = 3;

   typedef struct packed {
      logic temp_scan_on;
      logic rfid_scan_on;
      logic send_request;
      logic clear_request;
   } mode_out_type;

endpackage

>>> hdl/debounced_button_mode_panel_unit.sv
// Top level of the debounced button mode panel: input register, debounce lanes,
// mode logic and result register. Depends on dbmp_pkg, dbmp_debounce, dbmp_mode.

// One sample in, one result word out, one word per cycle sustained while rsp_stall
// is low. A sample sits in the input register, where the four debounce lanes (a
// subtract and compare each) and the mode logic update state and produce the
// result; the result register loads it as the sample leaves the input register,
// and drives it on rsp_. Only the low TIME_BITS bits of req_now_ms are used.
// csr_write_data sets the debounce time in ms (reset 100); write it only while
// no sample is in flight.
module debounced_button_mode_panel_unit import dbmp_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [NUM_BUTTONS-1:0]   req_pin_levels,
   input  logic [NOW_BITS-1:0]      req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [NUM_BUTTONS-1:0]   rsp_press_mask,
   output logic                     rsp_temp_scan_on,
   output logic                     rsp_rfid_scan_on,
   output logic                     rsp_send_request,
   output logic                     rsp_clear_request,
   input  logic                     csr_write_enable,
   input  logic [DEBOUNCE_BITS-1:0] csr_write_data
);

   logic [DEBOUNCE_BITS-1:0] debounce_ms_ff;
   logic                     in_valid_ff;
   logic [NUM_BUTTONS-1:0]   in_levels_ff;
   logic [TIME_BITS-1:0]     in_now_ff;
   logic                     out_valid_ff;
   logic [NUM_BUTTONS-1:0]   out_press_ff;
   mode_out_type             out_mode_ff;
   logic                     fire;
   logic                     req_take;
   logic [NUM_BUTTONS-1:0]   press_mask;
   mode_out_type             mode_out;

   // sample leaves the input register when the result register is free
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         debounce_ms_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_levels_ff <= req_pin_levels;
         in_now_ff    <= req_now_ms[TIME_BITS-1:0];
      end
   end

   dbmp_debounce #(
      .TIME_BITS (TIME_BITS)
   ) u_debounce (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .levels      (in_levels_ff),
      .now         (in_now_ff),
      .debounce_ms (debounce_ms_ff),
      .press_mask  (press_mask)
   );

   dbmp_mode u_mode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .press_mask (press_mask),
      .mode_out   (mode_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_press_ff <= press_mask;
         out_mode_ff  <= mode_out;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_press_mask    = out_press_ff;
   assign rsp_temp_scan_on  = out_mode_ff.temp_scan_on;
   assign rsp_rfid_scan_on  = out_mode_ff.rfid_scan_on;
   assign rsp_send_request  = out_mode_ff.send_request;
   assign rsp_clear_request = out_mode_ff.clear_request;

`ifndef ASSERT_OFF
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   a_clear_kills_enables: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clear_request) |-> (!rsp_temp_scan_on && !rsp_rfid_scan_on))
      else $error("clear request with a scan enable still on");

   a_pulses_follow_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_send_request == rsp_press_mask[BTN_SEND]
                     && rsp_clear_request == rsp_press_mask[BTN_CLEAR]))
      else $error("request pulse does not match press mask");

   a_result_follows_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed sample produced no result");
`endif

endmodule

>>> hdl/dbmp_debounce.sv
// Four-lane debounce: stable level and last-confirmed time per button.
// Depends on dbmp_pkg.
module dbmp_debounce import dbmp_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [NUM_BUTTONS-1:0]   levels,
   input  logic [TIME_BITS-1:0]     now,
   input  logic [DEBOUNCE_BITS-1:0] debounce_ms,
   output logic [NUM_BUTTONS-1:0]   press_mask
);

   logic [NUM_BUTTONS-1:0] stable_level_ff;
   logic [NUM_BUTTONS-1:0] stable_level_in;
   logic [TIME_BITS-1:0]   stable_since_ff [NUM_BUTTONS];
   logic [TIME_BITS-1:0]   stable_since_in [NUM_BUTTONS];

   always_comb begin
      logic [TIME_BITS-1:0] elapsed;
      elapsed = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         stable_level_in[i] = stable_level_ff[i];
         stable_since_in[i] = stable_since_ff[i];
         press_mask[i]      = 1'b0;
         if (levels[i] != stable_level_ff[i]) begin
            // wraps modulo 2^TIME_BITS
            elapsed = now - stable_since_ff[i];
            if (elapsed >= TIME_BITS'(debounce_ms)) begin
               stable_level_in[i] = levels[i];
               press_mask[i]      = ~levels[i];
            end
         end else begin
            stable_since_in[i] = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff <= '1;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            stable_since_ff[i] <= '0;
         end
      end else if (fire) begin
         stable_level_ff <= stable_level_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            stable_since_ff[i] <= stable_since_in[i];
         end
      end
   end

endmodule

>>> hdl/dbmp_mode.sv
// Mode logic: toggle phases and scan enables driven by accepted presses.
// Depends on dbmp_pkg.
module dbmp_mode import dbmp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [NUM_BUTTONS-1:0] press_mask,
   output mode_out_type           mode_out
);

   logic temp_phase_ff, temp_phase_in;
   logic temp_enable_ff, temp_enable_in;
   logic rfid_phase_ff, rfid_phase_in;
   logic rfid_enable_ff, rfid_enable_in;

   always_comb begin
      temp_phase_in  = temp_phase_ff;
      temp_enable_in = temp_enable_ff;
      rfid_phase_in  = rfid_phase_ff;
      rfid_enable_in = rfid_enable_ff;
      if (press_mask[BTN_TEMP]) begin
         temp_phase_in  = ~temp_phase_ff;
         temp_enable_in = ~temp_phase_ff;
      end
      if (press_mask[BTN_BADGE]) begin
         rfid_phase_in  = ~rfid_phase_ff;
         rfid_enable_in = ~rfid_phase_ff;
      end
      // clear acts last: enables off, phases kept
      if (press_mask[BTN_CLEAR]) begin
         temp_enable_in = 1'b0;
         rfid_enable_in = 1'b0;
      end
   end

   always_comb begin
      mode_out.temp_scan_on  = temp_enable_in;
      mode_out.rfid_scan_on  = rfid_enable_in;
      mode_out.send_request  = press_mask[BTN_SEND];
      mode_out.clear_request = press_mask[BTN_CLEAR];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_phase_ff  <= 1'b0;
         temp_enable_ff <= 1'b0;
         rfid_phase_ff  <= 1'b0;
         rfid_enable_ff <= 1'b0;
      end else if (fire) begin
         temp_phase_ff  <= temp_phase_in;
         temp_enable_ff <= temp_enable_in;
         rfid_phase_ff  <= rfid_phase_in;
         rfid_enable_ff <= rfid_enable_in;
      end
   end

endmodule
